// File: src/grid_a_star_path_planner_core_macros.svh
// assertion macros for the grid path planner
`ifndef GRID_A_STAR_PATH_PLANNER_CORE_MACROS_SVH
`define GRID_A_STAR_PATH_PLANNER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GAPP_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GAPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GAPP_ASSERT_IMM(label, clk, rst_n, ante, cons, msg)
`define GAPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/gapp_pkg.sv
// constants, node type and helper functions of the grid path planner
package gapp_pkg;

    localparam int GRID_SIDE    = 128;
    localparam int OPEN_DEPTH   = 1024;
    localparam int CLOSED_DEPTH = 1024;

    localparam int CW         = (GRID_SIDE > 128) ? $clog2(GRID_SIDE) : 7;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int GA_W       = $clog2(GRID_CELLS);
    localparam int HI_W       = $clog2(OPEN_DEPTH);
    localparam int CI_W       = $clog2(CLOSED_DEPTH);
    localparam int EXP_W      = $clog2(CLOSED_DEPTH + 1);

    localparam int G_STEP   = 2000;
    localparam int H_MUL    = 2010;
    localparam int H_STOP   = 4000;
    localparam int SMOOTH_N = 100;

    localparam int G_W = $clog2(G_STEP * (CLOSED_DEPTH + 1) + 1);
    localparam int H_W = $clog2(H_MUL * 2 * (1 << CW) + (1 << CW)) + 1;
    localparam int F_W = ((G_W > H_W) ? G_W : H_W) + 1;

    localparam logic [3:0] MARK_OPEN = 4'd3;
    localparam logic [3:0] MARK_PATH = 4'd4;
    localparam logic [3:0] MARK_GOAL = 4'd9;
    localparam logic [3:0] CELL_FREE = 4'd0;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    localparam logic [2:0] ST_DONE        = 3'd0;
    localparam logic [2:0] ST_FOUND       = 3'd1;
    localparam logic [2:0] ST_OVERFLOW    = 3'd2;
    localparam logic [2:0] ST_CLOSED_FULL = 3'd3;
    localparam logic [2:0] ST_NO_PATH     = 3'd4;

    typedef struct packed {
        logic [CW-1:0]  x;
        logic [CW-1:0]  y;
        logic [CW-1:0]  px;
        logic [CW-1:0]  py;
        logic [G_W-1:0] g;
        logic [H_W-1:0] h;
        logic [F_W-1:0] f;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    function automatic logic [H_W-1:0] heur(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [CW-1:0] gx, input logic [CW-1:0] gy);
        logic [CW-1:0] dx;
        logic [CW-1:0] dy;
        logic [CW-1:0] dd;
        logic [CW:0]   s;
        dx = (x > gx) ? x - gx : gx - x;
        dy = (y > gy) ? y - gy : gy - y;
        dd = (dx > dy) ? dx - dy : dy - dx;
        s  = {1'b0, dx} + {1'b0, dy};
        return H_W'(s) * H_W'(H_MUL) + H_W'(dd);
    endfunction

    function automatic logic on_grid(input logic [CW:0] x, input logic [CW:0] y);
        return (int'(x) < GRID_SIDE) && (int'(y) < GRID_SIDE);
    endfunction

    function automatic logic [GA_W-1:0] cell_addr(input logic [CW:0] x, input logic [CW:0] y);
        return GA_W'(int'(x) * GRID_SIDE + int'(y));
    endfunction

endpackage

// File: src/grid_a_star_path_planner_core.sv
// grid path planner top level: command sequencer over grid, heap and closed-list rams
//
// channel   dir  signals
// command   in   start, cmd, pos_x, pos_y, cell_value, goal_x, goal_y (busy is an output)
// result    out  done, read_value, status, closed_count
//
// cell write: answered from S_IDLE, cell read: answered from S_RD_WAIT (one registered grid ram read)
// run: per expansion the pop reads the root and the last entry and sifts down level by level,
// then closes the node; each off-grid neighbor is skipped, each grid neighbor is read and, if
// free, pushed with a sift-up level by level, then the end test; trace marks each path cell and
// scans closed entries backwards; smoothing checks at most 100 entries; ram reads are registered
// reset clears control state only; the grid must be written before it is read or searched
// done is high for one cycle; the next command is taken in that same cycle
`include "grid_a_star_path_planner_core_macros.svh"

module grid_a_star_path_planner_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [6:0]  pos_x,
    input  logic [6:0]  pos_y,
    input  logic [3:0]  cell_value,
    input  logic [6:0]  goal_x,
    input  logic [6:0]  goal_y,
    output logic        done,
    output logic [3:0]  read_value,
    output logic [2:0]  status,
    output logic [10:0] closed_count
);

    import gapp_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RD_WAIT  = 5'd1;
    localparam logic [4:0] S_INIT     = 5'd2;
    localparam logic [4:0] S_POP      = 5'd3;
    localparam logic [4:0] S_POP_ROOT = 5'd4;
    localparam logic [4:0] S_POP_LAST = 5'd5;
    localparam logic [4:0] S_SD_LOOP  = 5'd6;
    localparam logic [4:0] S_SD_L     = 5'd7;
    localparam logic [4:0] S_SD_R     = 5'd8;
    localparam logic [4:0] S_CLOSE    = 5'd9;
    localparam logic [4:0] S_EXP_RD   = 5'd10;
    localparam logic [4:0] S_EXP_CHK  = 5'd11;
    localparam logic [4:0] S_SU_LOOP  = 5'd12;
    localparam logic [4:0] S_SU_CMP   = 5'd13;
    localparam logic [4:0] S_EXP_NEXT = 5'd14;
    localparam logic [4:0] S_END      = 5'd15;
    localparam logic [4:0] S_TR_TOP   = 5'd16;
    localparam logic [4:0] S_TR_CMP   = 5'd17;
    localparam logic [4:0] S_SM_TOP   = 5'd18;
    localparam logic [4:0] S_SM_NODE  = 5'd19;
    localparam logic [4:0] S_SM_RD    = 5'd20;
    localparam logic [4:0] S_SM_GET   = 5'd21;
    localparam logic [4:0] S_SM_DEC   = 5'd22;
    localparam logic [4:0] S_FINISH   = 5'd23;

    logic [4:0]       state_reg, state_next;
    logic             done_reg, done_next;
    logic [3:0]       rdv_reg, rdv_next;
    logic [2:0]       stat_reg, stat_next;
    logic [2:0]       rstat_reg, rstat_next;
    logic [HI_W-1:0]  ocnt_reg, ocnt_next;
    logic [HI_W-1:0]  hidx_reg, hidx_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    logic [EXP_W-1:0] walk_reg, walk_next;
    logic [CI_W-1:0]  cidx_reg, cidx_next;
    logic [1:0]       k_reg, k_next;
    logic [3:0]       four_reg, four_next;
    logic             nbin_reg, nbin_next;

    node_t            cur_reg, cur_next;
    node_t            mov_reg, mov_next;
    node_t            lch_reg, lch_next;
    logic [CW-1:0]    sx_reg, sx_next;
    logic [CW-1:0]    sy_reg, sy_next;
    logic [CW-1:0]    gx_reg, gx_next;
    logic [CW-1:0]    gy_reg, gy_next;

    logic             g_we;
    logic [GA_W-1:0]  g_waddr, g_raddr;
    logic [3:0]       g_wdata, g_rdata;
    logic             h_we;
    logic [HI_W-1:0]  h_waddr, h_raddr;
    node_t            h_wdata;
    logic [NODE_W-1:0] h_rdata;
    node_t            h_rnode;
    logic             c_we;
    logic [CI_W-1:0]  c_waddr, c_raddr;
    node_t            c_wdata;
    logic [NODE_W-1:0] c_rdata;
    node_t            c_rnode;

    logic [CW:0]      nb_x, nb_y;
    logic             nb_on;
    node_t            nb_node;
    node_t            start_node;
    logic [CW:0]      in_x, in_y, goal_xe, goal_ye, cur_xe, cur_ye;
    logic [HI_W:0]    sd_l, sd_r;
    logic             sd_has_r, sd_swap, sd_pick_l;
    logic [EXP_W-1:0] walk_m1;
    logic             wr_take;
    logic             heap_walk;

    assign h_rnode = node_t'(h_rdata);
    assign c_rnode = node_t'(c_rdata);

    gapp_ram #(.WIDTH(4), .DEPTH(GRID_CELLS)) u_grid_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gapp_ram #(.WIDTH(NODE_W), .DEPTH(OPEN_DEPTH)) u_heap_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    gapp_ram #(.WIDTH(NODE_W), .DEPTH(CLOSED_DEPTH)) u_closed_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    assign in_x    = (CW + 1)'(pos_x);
    assign in_y    = (CW + 1)'(pos_y);
    assign goal_xe = {1'b0, gx_reg};
    assign goal_ye = {1'b0, gy_reg};
    assign cur_xe  = {1'b0, cur_reg.x};
    assign cur_ye  = {1'b0, cur_reg.y};

    // neighbor order: left, right, down, up
    always_comb
    begin
        nb_x = cur_xe;
        nb_y = cur_ye;
        unique case (k_reg)
            2'd0: nb_x = cur_xe - (CW + 1)'(1);
            2'd1: nb_x = cur_xe + (CW + 1)'(1);
            2'd2: nb_y = cur_ye - (CW + 1)'(1);
            2'd3: nb_y = cur_ye + (CW + 1)'(1);
            default: nb_x = cur_xe;
        endcase
    end

    assign nb_on = on_grid(nb_x, nb_y);

    always_comb
    begin
        nb_node.x  = nb_x[CW-1:0];
        nb_node.y  = nb_y[CW-1:0];
        nb_node.px = cur_reg.x;
        nb_node.py = cur_reg.y;
        nb_node.g  = cur_reg.g + G_W'(G_STEP);
        nb_node.h  = heur(nb_x[CW-1:0], nb_y[CW-1:0], gx_reg, gy_reg);
        nb_node.f  = F_W'(nb_node.g) + F_W'(nb_node.h);
    end

    always_comb
    begin
        start_node.x  = sx_reg;
        start_node.y  = sy_reg;
        start_node.px = sx_reg;
        start_node.py = sy_reg;
        start_node.g  = '0;
        start_node.h  = heur(sx_reg, sy_reg, gx_reg, gy_reg);
        start_node.f  = F_W'(start_node.h);
    end

    assign sd_l      = {hidx_reg, 1'b0};
    assign sd_r      = sd_l + (HI_W + 1)'(1);
    assign sd_has_r  = sd_r <= {1'b0, ocnt_reg};
    assign sd_swap   = (mov_reg.f > lch_reg.f) || (sd_has_r && (mov_reg.f > h_rnode.f));
    assign sd_pick_l = !sd_has_r || (lch_reg.f <= h_rnode.f);
    assign walk_m1   = walk_reg - EXP_W'(1);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        rdv_next   = rdv_reg;
        stat_next  = stat_reg;
        rstat_next = rstat_reg;
        ocnt_next  = ocnt_reg;
        hidx_next  = hidx_reg;
        exp_next   = exp_reg;
        walk_next  = walk_reg;
        cidx_next  = cidx_reg;
        k_next     = k_reg;
        four_next  = four_reg;
        nbin_next  = nbin_reg;
        cur_next   = cur_reg;
        mov_next   = mov_reg;
        lch_next   = lch_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        g_we       = 1'b0;
        g_waddr    = '0;
        g_wdata    = '0;
        g_raddr    = '0;
        h_we       = 1'b0;
        h_waddr    = '0;
        h_wdata    = mov_reg;
        h_raddr    = '0;
        c_we       = 1'b0;
        c_waddr    = '0;
        c_wdata    = cur_reg;
        c_raddr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_WRITE:
                        begin
                            g_we      = on_grid(in_x, in_y);
                            g_waddr   = cell_addr(in_x, in_y);
                            g_wdata   = cell_value;
                            done_next = 1'b1;
                            rdv_next  = '0;
                            stat_next = ST_DONE;
                        end
                        CMD_READ:
                        begin
                            if (on_grid(in_x, in_y))
                            begin
                                g_raddr    = cell_addr(in_x, in_y);
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rdv_next  = '0;
                                stat_next = ST_DONE;
                            end
                        end
                        CMD_RUN:
                        begin
                            sx_next    = CW'(pos_x);
                            sy_next    = CW'(pos_y);
                            gx_next    = CW'(goal_x);
                            gy_next    = CW'(goal_y);
                            state_next = S_INIT;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rdv_next  = '0;
                            stat_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                rdv_next   = g_rdata;
                stat_next  = ST_DONE;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_INIT:
            begin
                g_we       = on_grid(goal_xe, goal_ye);
                g_waddr    = cell_addr(goal_xe, goal_ye);
                g_wdata    = MARK_GOAL;
                h_we       = 1'b1;
                h_waddr    = HI_W'(1);
                h_wdata    = start_node;
                ocnt_next  = HI_W'(1);
                exp_next   = '0;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (ocnt_reg == '0)
                begin
                    rstat_next = ST_NO_PATH;
                    state_next = S_FINISH;
                end
                else
                begin
                    h_raddr    = HI_W'(1);
                    state_next = S_POP_ROOT;
                end
            end
            S_POP_ROOT:
            begin
                cur_next   = h_rnode;
                h_raddr    = ocnt_reg;
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                mov_next   = h_rnode;
                ocnt_next  = ocnt_reg - HI_W'(1);
                hidx_next  = HI_W'(1);
                state_next = S_SD_LOOP;
            end
            S_SD_LOOP:
            begin
                if (sd_l > {1'b0, ocnt_reg})
                begin
                    h_we       = 1'b1;
                    h_waddr    = hidx_reg;
                    state_next = S_CLOSE;
                end
                else
                begin
                    h_raddr    = sd_l[HI_W-1:0];
                    state_next = S_SD_L;
                end
            end
            S_SD_L:
            begin
                lch_next   = h_rnode;
                h_raddr    = sd_r[HI_W-1:0];
                state_next = S_SD_R;
            end
            S_SD_R:
            begin
                h_we    = 1'b1;
                h_waddr = hidx_reg;
                if (!sd_swap)
                begin
                    state_next = S_CLOSE;
                end
                else
                begin
                    h_wdata    = sd_pick_l ? lch_reg : h_rnode;
                    hidx_next  = sd_pick_l ? sd_l[HI_W-1:0] : sd_r[HI_W-1:0];
                    state_next = S_SD_LOOP;
                end
            end
            S_CLOSE:
            begin
                c_we       = 1'b1;
                c_waddr    = exp_reg[CI_W-1:0];
                exp_next   = exp_reg + EXP_W'(1);
                k_next     = '0;
                state_next = S_EXP_RD;
            end
            S_EXP_RD:
            begin
                if (nb_on)
                begin
                    g_raddr    = cell_addr(nb_x, nb_y);
                    state_next = S_EXP_CHK;
                end
                else
                begin
                    state_next = S_EXP_NEXT;
                end
            end
            S_EXP_CHK:
            begin
                if (g_rdata == CELL_FREE)
                begin
                    g_we    = 1'b1;
                    g_waddr = cell_addr(nb_x, nb_y);
                    g_wdata = MARK_OPEN;
                    if (ocnt_reg >= HI_W'(OPEN_DEPTH - 1))
                    begin
                        rstat_next = ST_OVERFLOW;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ocnt_next  = ocnt_reg + HI_W'(1);
                        hidx_next  = ocnt_reg + HI_W'(1);
                        mov_next   = nb_node;
                        state_next = S_SU_LOOP;
                    end
                end
                else
                begin
                    state_next = S_EXP_NEXT;
                end
            end
            S_SU_LOOP:
            begin
                if (hidx_reg > HI_W'(1))
                begin
                    h_raddr    = hidx_reg >> 1;
                    state_next = S_SU_CMP;
                end
                else
                begin
                    h_we       = 1'b1;
                    h_waddr    = hidx_reg;
                    state_next = S_EXP_NEXT;
                end
            end
            S_SU_CMP:
            begin
                h_we    = 1'b1;
                h_waddr = hidx_reg;
                if (mov_reg.f < h_rnode.f)
                begin
                    h_wdata    = h_rnode;
                    hidx_next  = hidx_reg >> 1;
                    state_next = S_SU_LOOP;
                end
                else
                begin
                    state_next = S_EXP_NEXT;
                end
            end
            S_EXP_NEXT:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = S_END;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_EXP_RD;
                end
            end
            S_END:
            begin
                if ((int'(cur_reg.h) > H_STOP) && (int'(exp_reg) < CLOSED_DEPTH))
                begin
                    state_next = S_POP;
                end
                else
                begin
                    rstat_next = (int'(cur_reg.h) <= H_STOP) ? ST_FOUND : ST_CLOSED_FULL;
                    walk_next  = exp_reg;
                    state_next = S_TR_TOP;
                end
            end
            S_TR_TOP:
            begin
                if (cur_reg.g == '0)
                begin
                    walk_next  = '0;
                    state_next = S_SM_TOP;
                end
                else
                begin
                    g_we    = on_grid(cur_xe, cur_ye);
                    g_waddr = cell_addr(cur_xe, cur_ye);
                    g_wdata = MARK_PATH;
                    if (walk_reg == '0)
                    begin
                        state_next = S_SM_TOP;
                    end
                    else
                    begin
                        cidx_next  = walk_m1[CI_W-1:0];
                        c_raddr    = walk_m1[CI_W-1:0];
                        state_next = S_TR_CMP;
                    end
                end
            end
            S_TR_CMP:
            begin
                if ((c_rnode.x == cur_reg.px) && (c_rnode.y == cur_reg.py))
                begin
                    cur_next   = c_rnode;
                    walk_next  = EXP_W'(cidx_reg);
                    state_next = S_TR_TOP;
                end
                else if (cidx_reg == '0)
                begin
                    walk_next  = '0;
                    state_next = S_SM_TOP;
                end
                else
                begin
                    cidx_next = cidx_reg - CI_W'(1);
                    c_raddr   = cidx_reg - CI_W'(1);
                end
            end
            S_SM_TOP:
            begin
                if ((walk_reg >= exp_reg) || (int'(walk_reg) >= SMOOTH_N))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    c_raddr    = walk_reg[CI_W-1:0];
                    state_next = S_SM_NODE;
                end
            end
            S_SM_NODE:
            begin
                cur_next   = c_rnode;
                k_next     = '0;
                state_next = S_SM_RD;
            end
            S_SM_RD:
            begin
                nbin_next  = nb_on;
                g_raddr    = cell_addr(nb_x, nb_y);
                state_next = S_SM_GET;
            end
            S_SM_GET:
            begin
                four_next[k_reg] = nbin_reg && (g_rdata == MARK_PATH);
                if (k_reg == 2'd3)
                begin
                    state_next = S_SM_DEC;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_SM_RD;
                end
            end
            S_SM_DEC:
            begin
                g_we       = (four_reg[0] || four_reg[1]) && (four_reg[2] || four_reg[3])
                             && on_grid(cur_xe, cur_ye);
                g_waddr    = cell_addr(cur_xe, cur_ye);
                g_wdata    = MARK_OPEN;
                walk_next  = walk_reg + EXP_W'(1);
                state_next = S_SM_TOP;
            end
            S_FINISH:
            begin
                done_next  = 1'b1;
                rdv_next   = '0;
                stat_next  = rstat_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            rdv_reg   <= '0;
            stat_reg  <= ST_DONE;
            rstat_reg <= ST_DONE;
            ocnt_reg  <= '0;
            hidx_reg  <= '0;
            exp_reg   <= '0;
            walk_reg  <= '0;
            cidx_reg  <= '0;
            k_reg     <= '0;
            four_reg  <= '0;
            nbin_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            rdv_reg   <= rdv_next;
            stat_reg  <= stat_next;
            rstat_reg <= rstat_next;
            ocnt_reg  <= ocnt_next;
            hidx_reg  <= hidx_next;
            exp_reg   <= exp_next;
            walk_reg  <= walk_next;
            cidx_reg  <= cidx_next;
            k_reg     <= k_next;
            four_reg  <= four_next;
            nbin_reg  <= nbin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        mov_reg <= mov_next;
        lch_reg <= lch_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign read_value   = rdv_reg;
    assign status       = stat_reg;
    assign closed_count = 11'(exp_reg);

    assign wr_take   = start && !busy && (cmd == CMD_WRITE);
    assign heap_walk = (state_reg == S_SU_LOOP) || (state_reg == S_SD_LOOP);

    `GAPP_ASSERT_IMM(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "result off idle")
    `GAPP_ASSERT_NXT(a_write_one, clk, rst_n, wr_take, done_reg, "cell write not answered")
    `GAPP_ASSERT_IMM(a_heap_slot, clk, rst_n, heap_walk, hidx_reg != '0, "heap slot zero")
    `GAPP_ASSERT_IMM(a_closed_room, clk, rst_n, state_reg == S_CLOSE,
        int'(exp_reg) < CLOSED_DEPTH, "closed list full")

endmodule

// File: src/gapp_ram.sv
// generic single-write, single-read ram with registered read
module gapp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: tb/sv/grid_planner_checker.sv
// result checker for the grid path planner: predicts every command and compares results
module grid_planner_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [6:0]  pos_x,
    input  logic [6:0]  pos_y,
    input  logic [3:0]  cell_value,
    input  logic [6:0]  goal_x,
    input  logic [6:0]  goal_y,
    input  logic        done,
    input  logic [3:0]  read_value,
    input  logic [2:0]  status,
    input  logic [10:0] closed_count,
    output int          errors,
    output int          pending
);

    import gapp_pkg::*;

    typedef struct {
        int x;
        int y;
        int px;
        int py;
        int g;
        int h;
        int f;
    } search_node_t;

    typedef struct packed {
        logic [3:0]  rd;
        logic [2:0]  st;
        logic [10:0] cnt;
    } planner_result_t;

    logic [3:0]      cells [0:GRID_CELLS-1];
    search_node_t    heap [0:OPEN_DEPTH-1];
    search_node_t    closed [0:CLOSED_DEPTH-1];
    int              heap_size;
    int              expanded;
    planner_result_t result_q [$];

    function automatic bit bool_on(input int x, input int y);
        return x >= 0 && y >= 0 && x < GRID_SIDE && y < GRID_SIDE;
    endfunction

    function automatic int cell_at(input int x, input int y);
        return bool_on(x, y) ? int'(cells[x * GRID_SIDE + y]) : 0;
    endfunction

    function automatic void cell_put(input int x, input int y, input logic [3:0] v);
        if (bool_on(x, y))
            cells[x * GRID_SIDE + y] = v;
    endfunction

    function automatic bit is_path(input int x, input int y);
        return bool_on(x, y) && cell_at(x, y) == int'(MARK_PATH);
    endfunction

    function automatic int abs_diff(input int a, input int b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic void score(inout search_node_t n, input int pg, input int gx,
                                  input int gy);
        int dx;
        int dy;
        dx = abs_diff(n.x, gx);
        dy = abs_diff(n.y, gy);
        n.g = pg + G_STEP;
        n.h = H_MUL * (dx + dy) + abs_diff(dx, dy);
        n.f = n.g + n.h;
    endfunction

    function automatic bit heap_insert(input search_node_t n);
        int i;
        search_node_t t;
        if (heap_size >= OPEN_DEPTH - 1)
            return 0;
        heap_size++;
        i = heap_size;
        heap[i] = n;
        while (i > 1 && heap[i].f < heap[i / 2].f)
        begin
            t = heap[i / 2];
            heap[i / 2] = heap[i];
            heap[i] = t;
            i = i / 2;
        end
        return 1;
    endfunction

    function automatic search_node_t heap_take();
        search_node_t root;
        search_node_t t;
        int i;
        int l;
        int r;
        int c;
        bit has_r;
        root = heap[1];
        i = 1;
        heap[1] = heap[heap_size];
        heap_size--;
        while (2 * i <= heap_size)
        begin
            l = 2 * i;
            r = l + 1;
            has_r = r <= heap_size;
            if (!(heap[i].f > heap[l].f || (has_r && heap[i].f > heap[r].f)))
                break;
            c = (!has_r || heap[l].f <= heap[r].f) ? l : r;
            t = heap[c];
            heap[c] = heap[i];
            heap[i] = t;
            i = c;
        end
        return root;
    endfunction

    function automatic bit visit_neighbors(input search_node_t cur, input int gx,
                                           input int gy);
        int dxs [4] = '{-1, 1, 0, 0};
        int dys [4] = '{0, 0, -1, 1};
        int nx;
        int ny;
        search_node_t n;
        for (int k = 0; k < 4; k++)
        begin
            nx = cur.x + dxs[k];
            ny = cur.y + dys[k];
            if (bool_on(nx, ny) && cell_at(nx, ny) == int'(CELL_FREE))
            begin
                cell_put(nx, ny, MARK_OPEN);
                n.x = nx;
                n.y = ny;
                n.px = cur.x;
                n.py = cur.y;
                score(n, cur.g, gx, gy);
                if (!heap_insert(n))
                    return 0;
            end
        end
        return 1;
    endfunction

    function automatic void mark_path();
        int lim;
        bit found;
        search_node_t cur;
        lim = expanded - 1;
        cur = closed[lim];
        while (cur.g >= 1)
        begin
            found = 0;
            cell_put(cur.x, cur.y, MARK_PATH);
            for (int i = lim; i >= 0; i--)
            begin
                if (closed[i].x == cur.px && closed[i].y == cur.py)
                begin
                    cur = closed[i];
                    lim = i - 1;
                    found = 1;
                    break;
                end
            end
            if (!found)
                break;
        end
    endfunction

    function automatic void cut_corners();
        int n;
        int x;
        int y;
        n = expanded < SMOOTH_N ? expanded : SMOOTH_N;
        for (int i = 0; i < n; i++)
        begin
            x = closed[i].x;
            y = closed[i].y;
            if ((is_path(x - 1, y) || is_path(x + 1, y)) &&
                (is_path(x, y + 1) || is_path(x, y - 1)))
                cell_put(x, y, MARK_OPEN);
        end
    endfunction

    function automatic logic [2:0] plan_route(input int sx, input int sy, input int gx,
                                              input int gy);
        search_node_t s;
        heap_size = 0;
        expanded = 0;
        cell_put(gx, gy, MARK_GOAL);
        s.x = sx;
        s.y = sy;
        s.px = sx;
        s.py = sy;
        score(s, -G_STEP, gx, gy);
        if (!heap_insert(s))
            return ST_OVERFLOW;
        do
        begin
            if (heap_size == 0)
                return ST_NO_PATH;
            closed[expanded] = heap_take();
            expanded++;
            if (!visit_neighbors(closed[expanded - 1], gx, gy))
                return ST_OVERFLOW;
        end
        while (closed[expanded - 1].h > H_STOP && expanded < CLOSED_DEPTH);
        mark_path();
        cut_corners();
        return closed[expanded - 1].h <= H_STOP ? ST_FOUND : ST_CLOSED_FULL;
    endfunction

    function automatic planner_result_t predict_command();
        planner_result_t r;
        r.rd = '0;
        r.st = ST_DONE;
        if (cmd == CMD_WRITE)
            cell_put(int'(pos_x), int'(pos_y), cell_value);
        else if (cmd == CMD_READ)
            r.rd = 4'(cell_at(int'(pos_x), int'(pos_y)));
        else if (cmd == CMD_RUN)
            r.st = plan_route(int'(pos_x), int'(pos_y), int'(goal_x), int'(goal_y));
        r.cnt = 11'(expanded);
        return r;
    endfunction

    always @(posedge clk)
    begin
        planner_result_t want;
        if (!rst_n)
        begin
            errors = 0;
            heap_size = 0;
            expanded = 0;
            result_q.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result rd=%0d st=%0d cnt=%0d", $time,
                             read_value, status, closed_count);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (read_value !== want.rd)
                    begin
                        errors++;
                        $display("%0t: read_value expected %0d actual %0d", $time,
                                 want.rd, read_value);
                    end
                    if (status !== want.st)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.st, status);
                    end
                    if (closed_count !== want.cnt)
                    begin
                        errors++;
                        $display("%0t: closed_count expected %0d actual %0d", $time,
                                 want.cnt, closed_count);
                    end
                end
            end
            if (start && !busy)
                result_q.push_back(predict_command());
            pending = result_q.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// testbench top for the grid path planner: stimulus, watchdog and verdict
module tb_top;
    import gapp_pkg::*;

    localparam int ITEM_GOAL  = 1600;
    localparam int IDLE_LIMIT = 2000000;
    localparam int OPEN_SIDE  = 34;
    localparam int FAR_LO     = GRID_SIDE - 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [6:0]  pos_x;
    logic [6:0]  pos_y;
    logic [3:0]  cell_value;
    logic [6:0]  goal_x;
    logic [6:0]  goal_y;
    logic        done;
    logic [3:0]  read_value;
    logic [2:0]  status;
    logic [10:0] closed_count;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          items;
    bit          no_gaps;

    grid_a_star_path_planner_core u_top (.*);

    grid_planner_checker u_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic issue(input logic [1:0] c, input int x, input int y, input int v,
                         input int gx, input int gy);
        start <= 1'b1;
        cmd <= c;
        pos_x <= 7'(x);
        pos_y <= 7'(y);
        cell_value <= 4'(v);
        goal_x <= 7'(gx);
        goal_y <= 7'(gy);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items++;
    endtask

    task automatic pause();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!no_gaps)
        begin
            if (r >= 97)
                n = $urandom_range(20, 60);
            else if (r >= 85)
                n = $urandom_range(4, 12);
            else if (r >= 50)
                n = $urandom_range(1, 3);
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic int clamp(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int rnd7();
        return $urandom_range(0, 127);
    endfunction

    initial
    begin
        int cx;
        int cy;
        int v;
        int n;
        int lo;
        int hi;
        int rlo;
        int rhi;
        clk = 0;
        rst_n = 0;
        start = 0;
        cmd = CMD_WRITE;
        pos_x = 0;
        pos_y = 0;
        cell_value = 0;
        goal_x = 0;
        goal_y = 0;
        idle_cycles = 0;
        items = 0;
        no_gaps = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two loaded squares, each closed off from the unloaded cells by a blocked ring
        for (int x = 0; x < OPEN_SIDE; x++)
        begin
            for (int y = 0; y < OPEN_SIDE; y++)
            begin
                v = (x == OPEN_SIDE - 1 || y == OPEN_SIDE - 1) ? $urandom_range(1, 15) : 0;
                issue(CMD_WRITE, x, y, v, rnd7(), rnd7());
                if ($urandom_range(0, 63) == 0)
                    pause();
            end
        end
        for (int x = FAR_LO; x < GRID_SIDE; x++)
        begin
            for (int y = FAR_LO; y < GRID_SIDE; y++)
            begin
                v = (x == FAR_LO || y == FAR_LO) ? $urandom_range(1, 15) : 0;
                issue(CMD_WRITE, x, y, v, rnd7(), rnd7());
            end
        end
        no_gaps = 0;

        // directed
        issue(CMD_WRITE, 127, 127, 15, 127, 127);
        issue(CMD_READ, 127, 127, 15, 0, 0);
        issue(CMD_WRITE, 127, 127, 0, 0, 0);
        issue(2'd3, 127, 127, 15, 127, 127);
        issue(CMD_READ, 127, 127, 0, 127, 127);
        issue(CMD_RUN, 0, 0, 0, 0, 0);
        issue(CMD_READ, 0, 0, 0, 0, 0);
        issue(CMD_RUN, 20, 20, 0, 127, 127);
        issue(CMD_RUN, 121, 121, 15, 126, 126);
        issue(CMD_READ, 126, 126, 0, 0, 0);
        issue(CMD_WRITE, 124, 124, 1, 0, 0);
        issue(CMD_WRITE, 124, 122, 1, 0, 0);
        issue(CMD_WRITE, 125, 123, 1, 0, 0);
        issue(CMD_WRITE, 123, 123, 1, 0, 0);
        issue(CMD_RUN, 124, 123, 0, 5, 5);
        issue(CMD_RUN, 127, 127, 0, 127, 125);
        drain();

        // random bursts around a focus cell, each ending in a run
        while (items < ITEM_GOAL)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
                drain();
            if ($urandom_range(0, 1))
            begin
                lo = 0;
                hi = OPEN_SIDE - 2;
            end
            else
            begin
                lo = FAR_LO + 1;
                hi = GRID_SIDE - 1;
            end
            cx = $urandom_range(hi, lo);
            cy = $urandom_range(hi, lo);
            if ($urandom_range(0, 9) == 0)
            begin
                cx = $urandom_range(0, 1) ? lo : hi;
                cy = $urandom_range(0, 1) ? lo : hi;
            end
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                v = ($urandom_range(0, 99) < 65) ? 0 : $urandom_range(1, 15);
                issue(CMD_WRITE, clamp(cx + int'($urandom_range(0, 4)) - 2, lo, hi),
                      clamp(cy + int'($urandom_range(0, 4)) - 2, lo, hi), v, rnd7(), rnd7());
                pause();
            end
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                if ($urandom_range(0, 1))
                begin
                    rlo = 0;
                    rhi = OPEN_SIDE - 1;
                end
                else
                begin
                    rlo = FAR_LO;
                    rhi = GRID_SIDE - 1;
                end
                issue(CMD_READ, $urandom_range(rhi, rlo), $urandom_range(rhi, rlo),
                      $urandom_range(0, 15), rnd7(), rnd7());
                pause();
            end
            if ($urandom_range(0, 29) == 0)
            begin
                issue(2'd3, rnd7(), rnd7(), $urandom_range(0, 15), rnd7(), rnd7());
                pause();
            end
            if ($urandom_range(0, 9) == 0)
                issue(CMD_RUN, cx, cy, $urandom_range(0, 15), rnd7(), rnd7());
            else
                issue(CMD_RUN, cx, cy, $urandom_range(0, 15),
                      clamp(cx + int'($urandom_range(0, 6)) - 3, 0, GRID_SIDE - 1),
                      clamp(cy + int'($urandom_range(0, 6)) - 3, 0, GRID_SIDE - 1));
            pause();
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/gapp_pkg.sv
src/gapp_ram.sv
src/grid_a_star_path_planner_core.sv
tb/sv/grid_planner_checker.sv
tb/sv/tb_top.sv
